// ----- rtl/core/sorted_timer_queue_macros.svh -----
// assertion macros for the sorted timer queue
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// condition now implies consequence now
`define STQ_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("sorted_timer_queue: assertion failed");
// condition now implies consequence in the next cycle
`define STQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("sorted_timer_queue: assertion failed");
`else
`define STQ_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define STQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// ----- rtl/core/stq_pkg.sv -----
// shared types and constants for the sorted timer queue
`timescale 1ns / 1ps
package stq_pkg;
  localparam int ENTRIES   = 16;
  localparam int TIME_BITS = 32;
  localparam int MAX_OUT   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int K_W       = $clog2(MAX_OUT + 1);
  localparam int SLOT_W    = 4;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_TICK   = 2'd3
  } stq_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 3'd0,
    ST_BUSY     = 3'd1,
    ST_UNLISTED = 3'd2,
    ST_EXPIRED  = 3'd3,
    ST_NONE     = 3'd4
  } stq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FIND,
    S_TICK
  } stq_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_INSERT,
    OP_REMOVE,
    OP_SET_EXP
  } stq_op_t;

  typedef struct packed {
    stq_op_t     op;
    logic        set_exp;
    logic        clr_listed;
    logic        emit;
    stq_status_t emit_status;
    logic        emit_last;
    logic        emit_head;
  } stq_ctrl_t;

  typedef struct packed {
    stq_cmd_t cmd;
    logic     slot_bad;
    logic     listed;
    logic     at_end;
    logic     exp_gt;
    logic     slot_match;
    logic     succ_ok;
    logic     head_exp;
    logic     next_exp;
    logic     k_zero;
    logic     k_last;
  } stq_flags_t;
endpackage

// ----- rtl/core/stq_datapath.sv -----
// list storage, scan index and result register of the sorted timer queue
`timescale 1ns / 1ps
module stq_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stq_pkg::stq_ctrl_t           ctrl,
  input  logic [stq_pkg::CMD_W-1:0]    in_command,
  input  logic [stq_pkg::SLOT_W-1:0]   in_slot,
  input  logic [stq_pkg::TIME_BITS-1:0] in_expiry_time,
  input  logic [stq_pkg::TIME_BITS-1:0] in_current_time,
  output stq_pkg::stq_flags_t          flags,
  output logic                         out_strobe,
  output logic [stq_pkg::STAT_W-1:0]   out_status,
  output logic [stq_pkg::SLOT_W-1:0]   out_result_slot,
  output logic [stq_pkg::TIME_BITS-1:0] out_result_expiry,
  output logic                         out_last_of_run
);
  import stq_pkg::*;

  logic [IDX_W-1:0]     order_r [ENTRIES];
  logic [TIME_BITS-1:0] expiry_r [ENTRIES];
  logic [ENTRIES-1:0]   listed_r;
  logic [CNT_W-1:0]     count_r;
  logic [IDX_W-1:0]     idx_r;
  logic [K_W-1:0]       k_r;
  stq_cmd_t             cmd_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [TIME_BITS-1:0] exp_r;
  logic [TIME_BITS-1:0] now_r;

  logic                 strobe_r;
  logic [STAT_W-1:0]    status_r;
  logic [SLOT_W-1:0]    rslot_r;
  logic [TIME_BITS-1:0] rexp_r;
  logic                 last_r;

  logic [IDX_W-1:0]     slot_ix;
  logic [IDX_W-1:0]     idx_p1;
  logic [IDX_W-1:0]     cur_slot;
  logic [IDX_W-1:0]     head_slot;
  logic [IDX_W-1:0]     sec_slot;

  assign slot_ix   = IDX_W'(slot_r);
  assign idx_p1    = idx_r + 1'b1;
  assign cur_slot  = order_r[idx_r];
  assign head_slot = order_r[0];
  assign sec_slot  = order_r[1];

  always_comb begin
    flags.cmd        = cmd_r;
    flags.slot_bad   = int'(slot_r) >= ENTRIES;
    flags.listed     = listed_r[slot_ix];
    flags.at_end     = CNT_W'(idx_r) == count_r;
    flags.exp_gt     = expiry_r[cur_slot] > exp_r;
    flags.slot_match = cur_slot == slot_ix;
    flags.succ_ok    = (CNT_W'(idx_r) + CNT_W'(1) < count_r) &&
                       !(exp_r < expiry_r[order_r[idx_p1]]);
    flags.head_exp   = (count_r != '0) && !(now_r < expiry_r[head_slot]);
    flags.next_exp   = (count_r > CNT_W'(1)) && !(now_r < expiry_r[sec_slot]);
    flags.k_zero     = k_r == '0;
    flags.k_last     = k_r == K_W'(MAX_OUT - 1);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listed_r <= '0;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctrl.emit;
      if (ctrl.op == OP_INSERT) begin
        listed_r[slot_ix] <= 1'b1;
        count_r           <= count_r + CNT_W'(1);
      end else if (ctrl.op == OP_REMOVE) begin
        if (ctrl.clr_listed) listed_r[cur_slot] <= 1'b0;
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // payload: list order, expiries, latched request, result register
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        cmd_r  <= stq_cmd_t'(in_command);
        slot_r <= in_slot;
        exp_r  <= in_expiry_time;
        now_r  <= in_current_time;
        idx_r  <= '0;
        k_r    <= '0;
      end
      OP_STEP: idx_r <= idx_p1;
      OP_INSERT: begin
        for (int j = 1; j < ENTRIES; j++) begin
          if (IDX_W'(j) > idx_r) order_r[j] <= order_r[j-1];
        end
        order_r[idx_r] <= slot_ix;
      end
      OP_REMOVE: begin
        for (int j = 0; j < ENTRIES - 1; j++) begin
          if (IDX_W'(j) >= idx_r) order_r[j] <= order_r[j+1];
        end
        if (ctrl.emit_head) k_r <= k_r + K_W'(1);
      end
      default: ;
    endcase
    if (ctrl.set_exp) expiry_r[slot_ix] <= exp_r;
    if (ctrl.emit) begin
      status_r <= ctrl.emit_status;
      last_r   <= ctrl.emit_last;
      rslot_r  <= ctrl.emit_head ? SLOT_W'(head_slot) :
                  (ctrl.emit_status == ST_NONE ? '0 : slot_r);
      rexp_r   <= ctrl.emit_head ? expiry_r[head_slot] : '0;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_result_slot   = rslot_r;
  assign out_result_expiry = rexp_r;
  assign out_last_of_run   = last_r;
endmodule

// ----- rtl/core/stq_ctrl.sv -----
// sequencing state machine of the sorted timer queue
`timescale 1ns / 1ps
module stq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  stq_pkg::stq_flags_t flags,
  output stq_pkg::stq_ctrl_t  ctrl,
  output logic                busy
);
  import stq_pkg::*;

  stq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    ctrl.op          = OP_NONE;
    ctrl.set_exp     = 1'b0;
    ctrl.clr_listed  = 1'b0;
    ctrl.emit        = 1'b0;
    ctrl.emit_status = ST_DONE;
    ctrl.emit_last   = 1'b1;
    ctrl.emit_head   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.op   = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (flags.cmd == CMD_TICK) begin
          state_nxt = S_TICK;
        end else if (flags.slot_bad) begin
          ctrl.emit = 1'b1; ctrl.emit_status = ST_UNLISTED; state_nxt = S_IDLE;
        end else if (flags.cmd == CMD_ADD) begin
          if (flags.listed) begin
            ctrl.emit = 1'b1; ctrl.emit_status = ST_BUSY; state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (!flags.listed) begin
          ctrl.emit = 1'b1; ctrl.emit_status = ST_UNLISTED; state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FIND;
        end
      end
      S_SCAN: begin
        if (flags.at_end || flags.exp_gt) begin
          ctrl.op      = OP_INSERT;
          ctrl.set_exp = 1'b1;
          ctrl.emit    = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          ctrl.op = OP_STEP;
        end
      end
      S_FIND: begin
        if (flags.at_end) begin
          ctrl.emit = 1'b1; ctrl.emit_status = ST_UNLISTED; state_nxt = S_IDLE;
        end else if (!flags.slot_match) begin
          ctrl.op = OP_STEP;
        end else if (flags.cmd == CMD_DELETE) begin
          ctrl.op = OP_REMOVE; ctrl.clr_listed = 1'b1;
          ctrl.emit = 1'b1; state_nxt = S_IDLE;
        end else begin
          ctrl.set_exp = 1'b1;
          if (flags.succ_ok) begin
            ctrl.op   = OP_REMOVE;
            state_nxt = S_SCAN;
          end else begin
            ctrl.emit = 1'b1; state_nxt = S_IDLE;
          end
        end
      end
      S_TICK: begin
        if (!flags.head_exp) begin
          ctrl.emit        = flags.k_zero;
          ctrl.emit_status = ST_NONE;
          state_nxt        = S_IDLE;
        end else begin
          ctrl.op          = OP_REMOVE;
          ctrl.clr_listed  = 1'b1;
          ctrl.emit        = 1'b1;
          ctrl.emit_head   = 1'b1;
          ctrl.emit_status = ST_EXPIRED;
          ctrl.emit_last   = !(flags.next_exp && !flags.k_last);
          if (ctrl.emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = state_r != S_IDLE;
endmodule

// ----- rtl/core/sorted_timer_queue.sv -----
// top level of the sorted timer queue
// sorted timer queue: up to sixteen timer slots held in a list ordered by
// expiry, equal expiries in the order they were placed
// request channel: drive in_command, in_slot, in_expiry_time and
// in_current_time with start high; the request is taken at a clock edge
// where busy is low, and busy drops as its last result is registered
// commands: add, adjust expiry, delete, tick (report and drop everything
// expired at the head, at most sixteen per tick)
// result channel: each result sits on the out_ ports for one cycle with
// out_strobe high; out_last_of_run marks the final result of a request
// the receiver cannot hold results back, so none are ever stalled
// add: load, decode, a scan one entry a cycle to the insert position,
// then the insert, which registers the result; adjust and delete scan
// to the slot, and an adjust with a move removes it and scans on to its
// new position; tick: load, decode, then one result a cycle; requests
// are served one at a time, a new one taken only once busy is low
// reset (synchronous, active low) empties the list and idles the block;
// slot expiries and list contents are not cleared, only the listed flags
`timescale 1ns / 1ps
`include "sorted_timer_queue_macros.svh"
module sorted_timer_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [stq_pkg::CMD_W-1:0]      in_command,
  input  logic [stq_pkg::SLOT_W-1:0]     in_slot,
  input  logic [stq_pkg::TIME_BITS-1:0]  in_expiry_time,
  input  logic [stq_pkg::TIME_BITS-1:0]  in_current_time,
  output logic                           out_strobe,
  output logic [stq_pkg::STAT_W-1:0]     out_status,
  output logic [stq_pkg::SLOT_W-1:0]     out_result_slot,
  output logic [stq_pkg::TIME_BITS-1:0]  out_result_expiry,
  output logic                           out_last_of_run
);
  import stq_pkg::*;

  stq_ctrl_t  ctrl;   // commands from the sequencer
  stq_flags_t flags;  // list status back to the sequencer

  stq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  stq_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .in_command        (in_command),
    .in_slot           (in_slot),
    .in_expiry_time    (in_expiry_time),
    .in_current_time   (in_current_time),
    .flags             (flags),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_result_slot   (out_result_slot),
    .out_result_expiry (out_result_expiry),
    .out_last_of_run   (out_last_of_run)
  );

  // no result can appear in the cycle straight after a request is taken
  `STQ_ASSERT_NEXT(a_no_early_result, clk, rst_n, start && !busy, !out_strobe)
  // the final result of a request leaves with the block already idle
  `STQ_ASSERT_NOW(a_last_idle, clk, rst_n, out_strobe && out_last_of_run, !busy)
  // a result that is not the last keeps the block busy
  `STQ_ASSERT_NOW(a_more_busy, clk, rst_n, out_strobe && !out_last_of_run, busy)
endmodule

// ----- verif/stq_checker.sv -----
// checker for the sorted timer queue: predicts results from requests and compares
`timescale 1ns / 1ps
module stq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_expiry_time,
  input  logic [31:0] in_current_time,
  input  logic        out_strobe,
  input  logic [2:0]  out_status,
  input  logic [3:0]  out_result_slot,
  input  logic [31:0] out_result_expiry,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import stq_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] expiry;
    logic        last;
  } timer_result_t;

  logic [3:0]  order_q[ENTRIES];
  logic [31:0] expiry_of[ENTRIES];
  logic        listed[ENTRIES];
  int          listed_n;
  timer_result_t pending_results[$];

  assign pending_count = pending_results.size();

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic timer_result_t mk(input stq_status_t st, input logic [3:0] sl,
                                       input logic [31:0] ex, input logic last);
    timer_result_t r;
    r.status = st; r.slot = sl; r.expiry = ex; r.last = last;
    return r;
  endfunction

  function automatic int first_later(input int from, input logic [31:0] t);
    for (int i = from; i < listed_n; i++)
      if (expiry_of[order_q[i]] > t) return i;
    return listed_n;
  endfunction

  task automatic insert_at(input int pos, input logic [3:0] s);
    for (int i = listed_n; i > pos; i--) order_q[i] = order_q[i-1];
    order_q[pos] = s;
    listed_n++;
  endtask

  task automatic remove_at(input int pos);
    for (int i = pos; i + 1 < listed_n; i++) order_q[i] = order_q[i+1];
    listed_n--;
  endtask

  task automatic predict_timer_request(input stq_cmd_t cmd, input logic [3:0] s,
                                       input logic [31:0] ex, input logic [31:0] now);
    int k;
    int p;
    logic [3:0] h;
    k = 0;
    if (cmd == CMD_TICK) begin
      while (listed_n > 0 && k < MAX_OUT) begin
        h = order_q[0];
        if (now < expiry_of[h]) break;
        pending_results.push_back(mk(ST_EXPIRED, h, expiry_of[h], 1'b0));
        listed[h] = 1'b0;
        remove_at(0);
        k++;
      end
      if (k == 0) pending_results.push_back(mk(ST_NONE, 4'd0, 32'd0, 1'b1));
      else pending_results[$].last = 1'b1;
    end else if (cmd == CMD_ADD) begin
      if (listed[s]) pending_results.push_back(mk(ST_BUSY, s, 32'd0, 1'b1));
      else begin
        expiry_of[s] = ex;
        insert_at(first_later(0, ex), s);
        listed[s] = 1'b1;
        pending_results.push_back(mk(ST_DONE, s, 32'd0, 1'b1));
      end
    end else if (!listed[s]) begin
      pending_results.push_back(mk(ST_UNLISTED, s, 32'd0, 1'b1));
    end else begin
      p = 0;
      while (order_q[p] != s) p++;
      if (cmd == CMD_DELETE) begin
        remove_at(p);
        listed[s] = 1'b0;
      end else begin
        expiry_of[s] = ex;
        // moves later only when not below its successor
        if (p + 1 < listed_n && !(ex < expiry_of[order_q[p+1]])) begin
          remove_at(p);
          insert_at(first_later(p + 1, ex), s);
        end
      end
      pending_results.push_back(mk(ST_DONE, s, 32'd0, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      listed_n = 0;
      for (int i = 0; i < ENTRIES; i++) listed[i] = 1'b0;
      pending_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (out_strobe) begin
        result_count++;
        if (pending_results.size() == 0)
          report_mismatch("result with nothing expected");
        else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d want %0d", out_status, want.status));
          if (out_result_slot !== want.slot)
            report_mismatch($sformatf("slot %0d want %0d", out_result_slot, want.slot));
          if (out_result_expiry !== want.expiry)
            report_mismatch($sformatf("expiry %0d want %0d", out_result_expiry,
                                      want.expiry));
          if (out_last_of_run !== want.last)
            report_mismatch($sformatf("last %0b want %0b", out_last_of_run, want.last));
        end
      end
      if (start && !busy)
        predict_timer_request(stq_cmd_t'(in_command), in_slot, in_expiry_time,
                              in_current_time);
    end
  end
endmodule

// ----- verif/tb.sv -----
// testbench top for the sorted timer queue: stimulus and verdict
`timescale 1ns / 1ps
module tb;
  import stq_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [3:0]  in_slot = '0;
  logic [31:0] in_expiry_time = '0;
  logic [31:0] in_current_time = '0;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [3:0]  out_result_slot;
  logic [31:0] out_result_expiry;
  logic        out_last_of_run;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          cycle_count = 0;
  int          request_count = 0;

  localparam int CYCLE_LIMIT = 400000;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sorted_timer_queue DUT (.*);

  stq_checker u_checker (.*);

  // watchdog against a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // hand one request over; start stays high until an edge with busy low takes it
  task automatic send_request(input stq_cmd_t cmd, input logic [3:0] s,
                              input logic [31:0] ex, input logic [31:0] now);
    in_command      <= cmd;
    in_slot         <= s;
    in_expiry_time  <= ex;
    in_current_time <= now;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    request_count++;
  endtask

  // mostly no gap or a short one, now and then a long one
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9);
    if (n < 4) n = 0;
    else if (n < 9) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // times clustered near a moving base so ties and orderings get exercised
  function automatic logic [31:0] near_time(input logic [31:0] base);
    case ($urandom_range(0, 9))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'd0;
      2:       return $urandom();
      default: return base + $urandom_range(0, 40);
    endcase
  endfunction

  initial begin
    logic [31:0] clock_now;
    int          pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, unlisted slots, extremes, ties, busy slot
    send_request(CMD_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);
    send_request(CMD_DELETE, 4'd5, 32'd0, 32'd0);
    send_request(CMD_ADJUST, 4'd15, 32'h5555_5555, 32'd0);
    send_request(CMD_ADD, 4'd0, 32'hFFFF_FFFF, 32'd0);
    send_request(CMD_ADD, 4'd15, 32'd0, 32'd0);
    send_request(CMD_ADD, 4'd7, 32'd100, 32'd0);
    send_request(CMD_ADD, 4'd8, 32'd100, 32'd0);
    send_request(CMD_ADD, 4'd7, 32'd1, 32'd0);
    // adjust not below successor: moves later
    send_request(CMD_ADJUST, 4'd7, 32'd100, 32'd0);
    // adjust below predecessor: keeps its place
    send_request(CMD_ADJUST, 4'd0, 32'd50, 32'd0);
    send_request(CMD_ADJUST, 4'd15, 32'hAAAA_AAAA, 32'd0);
    send_request(CMD_TICK, 4'd3, 32'hFFFF_FFFF, 32'd99);
    send_request(CMD_TICK, 4'd0, 32'd0, 32'd100);
    send_request(CMD_DELETE, 4'd0, 32'd0, 32'd0);
    send_request(CMD_DELETE, 4'd15, 32'd0, 32'd0);
    // fill all sixteen slots with equal expiry, then one tick drains them
    for (int i = 0; i < ENTRIES; i++) send_request(CMD_ADD, i[3:0], 32'd200, 32'd0);
    send_request(CMD_ADD, 4'd3, 32'd10, 32'd0);
    send_request(CMD_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);

    // random: mostly adds, adjusts and deletes with a moving clock
    clock_now = $urandom_range(0, 1000);
    repeat (75) begin
      idle_gap();
      pick = $urandom_range(0, 9);
      if (pick < 4)
        send_request(CMD_ADD, 4'($urandom_range(0, 15)), near_time(clock_now), $urandom());
      else if (pick < 6)
        send_request(CMD_ADJUST, 4'($urandom_range(0, 15)), near_time(clock_now),
                     $urandom());
      else if (pick < 8)
        send_request(CMD_DELETE, 4'($urandom_range(0, 15)), $urandom(), $urandom());
      else begin
        clock_now = clock_now + $urandom_range(0, 25);
        send_request(CMD_TICK, 4'($urandom_range(0, 15)), $urandom(),
                     ($urandom_range(0, 15) == 0) ? $urandom() : clock_now);
      end
    end
    start <= 1'b0;
    // drain anything still listed
    @(posedge clk);
    send_request(CMD_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);
    start <= 1'b0;

    while (pending_count > 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d requests and %0d results: adds, adjusts, deletes and ticks",
             request_count, result_count);
    $display("including busy and unlisted slots, ties, a full list and time extremes");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/stq_pkg.sv
rtl/core/stq_datapath.sv
rtl/core/stq_ctrl.sv
rtl/core/sorted_timer_queue.sv
verif/stq_checker.sv
verif/tb.sv
